/* sv/dnnr_pkg.sv */
// Shared types, constants and codes for the descriptor nearest-neighbor ratio block.
`default_nettype none

package dnnr_pkg;

  // Default sizes of the descriptor stores.
  localparam int MAX_MODELS_DEF = 256;
  localparam int MAX_LENGTH_DEF = 128;

  // Four descriptor elements share one memory word.
  localparam int LANES = 4;
  localparam int VAL_W = 16;
  localparam int SQ_W  = 32;
  localparam int SUM_W = 34;

  // Distances; the all-ones value means that no candidate was seen.
  localparam int DIST_W = 39;
  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  // Configuration registers.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int MODEL_COUNT_W = 9;
  localparam int DESC_LEN_W    = 8;
  localparam logic [MODEL_COUNT_W-1:0] MODEL_COUNT_RST = 9'd0;
  localparam logic [DESC_LEN_W-1:0]    DESC_LEN_RST    = 8'd64;

  typedef enum logic {
    REG_MODEL_COUNT = 1'b0,
    REG_DESC_LEN    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_MODEL = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic [6:0]         element_index;
    logic signed [15:0] value;
    logic               laplacian_sign;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic        match_found;
    logic [7:0]  neighbor_index;
    logic [38:0] best_distance;
    logic [38:0] second_distance;
  } out_item_t;

  // Control that travels with each memory word through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [LANES-1:0] mask;
  } word_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RATIO,
    ST_DONE
  } nn_state_t;

endpackage

`default_nettype wire

/* sv/descriptor_nearest_neighbor_ratio.sv */
// Top level of the descriptor nearest-neighbor search with ratio test.
`default_nettype none

// Model descriptor elements (func 0) and query elements (func 1) are written
// one item per cycle, while in_stall is low, into on-chip memories. The query
// item marked last starts a brute-force search over the first model_count
// entries (at most MAX_MODELS) whose laplacian sign equals the query's, using
// squared Euclidean distance on Q1.15 elements, and yields one result: best
// and second-best distance, and the best index when 5*best < 3*second. A
// search reads one 64-bit model word (four elements) per cycle from the
// single read port of the model memory; a model_count of zero skips the
// scan. in_stall stays high after the item that starts a search until its
// result is loaded into the output register, which waits for the previous
// result to leave.
// Memories need no clearing pass: entries that were never written are not
// meant to be searched. Registers: model_count at address 0, descriptor_length
// at address 4; write them only while no search is running.
module descriptor_nearest_neighbor_ratio
  import dnnr_pkg::*;
#(
  parameter int MAX_MODELS = MAX_MODELS_DEF,
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  in_item_t    in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output out_item_t         out_data,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [CFG_AW-1:0] paddr,
  input  wire  [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int QWORDS = (MAX_LENGTH + LANES - 1) / LANES;
  localparam int MA_W   = $clog2(MAX_MODELS * QWORDS);
  localparam int QA_W   = (QWORDS > 1) ? $clog2(QWORDS) : 1;
  localparam int QC_W   = $clog2(QWORDS + 1);
  localparam int EW     = $clog2(MAX_MODELS);
  localparam int CNT_W  = $clog2(MAX_MODELS + 1);
  localparam int XW     = (EW > 8) ? EW : 8;
  localparam int P_W    = DIST_W + 3;

  // Configuration.
  logic [MODEL_COUNT_W-1:0] model_count_r;
  logic [DESC_LEN_W-1:0]    desc_len_r;

  // Control.
  nn_state_t         state_r;
  nn_state_t         state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [DESC_LEN_W-1:0] len_r;
  logic [QC_W-1:0]   nwords_r;
  logic [QA_W-1:0]   word_r;
  logic [EW-1:0]     entry_r;
  logic [MA_W-1:0]   base_r;
  logic              qsign_r;
  word_tag_t         p1_tag_r;
  logic [EW-1:0]     p1_entry_r;

  // Search result.
  logic [DIST_W-1:0] best_r;
  logic [DIST_W-1:0] second_r;
  logic [EW-1:0]     bidx_r;
  logic [P_W-1:0]    prod5_r;
  logic [P_W-1:0]    prod3_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Input decode.
  logic              in_acc;
  logic [XW-1:0]     ent_ext;
  logic              ent_ok;
  logic              elem_ok;
  logic              model_we;
  logic              query_we;
  logic              start;
  logic [MA_W-1:0]   model_waddr;
  logic [DESC_LEN_W-1:0] len_eff;
  logic [DESC_LEN_W:0]   nw_sum;
  logic [QC_W-1:0]   nwords_eff;
  logic [CNT_W-1:0]  count_eff;

  // Scan.
  logic              word_last;
  logic              entry_last;
  word_tag_t         iss_tag;
  logic              out_free;
  logic              out_load;
  logic              match;

  // Store and pipeline.
  logic [LANES-1:0][VAL_W-1:0] model_rdata;
  logic [LANES-1:0][VAL_W-1:0] query_rdata;
  logic              sign_rdata;
  logic              dist_busy;
  logic              dist_valid;
  logic [DIST_W-1:0] entry_dist;
  logic [EW-1:0]     dist_entry;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_count_r <= MODEL_COUNT_RST;
      desc_len_r    <= DESC_LEN_RST;
    end else if (psel && penable && pwrite) begin
      case (cfg_reg_t'(paddr[2]))
        REG_MODEL_COUNT: model_count_r <= pwdata[MODEL_COUNT_W-1:0];
        REG_DESC_LEN:    desc_len_r    <= pwdata[DESC_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_MODEL_COUNT: prdata = CFG_DW'(model_count_r);
      REG_DESC_LEN:    prdata = CFG_DW'(desc_len_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  assign in_acc  = in_valid && !in_stall;
  assign ent_ext = XW'(in_data.entry_index);
  assign ent_ok  = {1'b0, ent_ext} < (XW+1)'(MAX_MODELS);
  assign elem_ok = {1'b0, in_data.element_index} < 8'(MAX_LENGTH);

  assign model_we = in_acc && (in_data.func == FUNC_MODEL) && ent_ok && elem_ok;
  assign query_we = in_acc && (in_data.func == FUNC_QUERY) && elem_ok;
  // An out-of-range query element is dropped, but its last mark still counts.
  assign start    = in_acc && (in_data.func == FUNC_QUERY) && in_data.last;

  assign model_waddr = MA_W'(ent_ext[EW-1:0]) * MA_W'(QWORDS) +
                       MA_W'(in_data.element_index >> 2);

  // Effective search bounds, latched when a search starts.
  assign len_eff = ({1'b0, desc_len_r} > 9'(MAX_LENGTH)) ? 8'(MAX_LENGTH) : desc_len_r;
  assign nw_sum  = ({1'b0, len_eff} + 9'd3) >> 2;
  // A length of zero still runs one fully masked word, giving distance zero.
  assign nwords_eff = (nw_sum == '0) ? QC_W'(1) : QC_W'(nw_sum);
  assign count_eff  = (32'(model_count_r) > 32'(MAX_MODELS)) ?
                      CNT_W'(MAX_MODELS) : CNT_W'(model_count_r);

  // ---------------------------------------------------------------- scan
  assign word_last  = QC_W'(word_r) == (nwords_r - QC_W'(1));
  assign entry_last = CNT_W'(entry_r) == (count_r - CNT_W'(1));

  always_comb begin
    iss_tag.valid = (state_r == ST_SCAN);
    iss_tag.first = (word_r == '0);
    iss_tag.last  = word_last;
    for (int l = 0; l < LANES; l++) begin
      iss_tag.mask[l] = 9'({word_r, 2'(l)}) < {1'b0, len_r};
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign match    = prod5_r < prod3_r;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (count_eff == '0) ? ST_RATIO : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (word_last && entry_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dist_busy) begin
          state_nxt = ST_RATIO;
        end
      end
      ST_RATIO: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_tag_r.valid <= 1'b0;
    end else begin
      p1_tag_r.valid <= iss_tag.valid;
    end
    p1_tag_r.first <= iss_tag.first;
    p1_tag_r.last  <= iss_tag.last;
    p1_tag_r.mask  <= iss_tag.mask;
    p1_entry_r     <= entry_r;

    if (start) begin
      count_r  <= count_eff;
      len_r    <= len_eff;
      nwords_r <= nwords_eff;
      qsign_r  <= in_data.laplacian_sign;
      word_r   <= '0;
      entry_r  <= '0;
      base_r   <= '0;
    end else if (state_r == ST_SCAN) begin
      if (word_last) begin
        word_r  <= '0;
        entry_r <= entry_r + EW'(1);
        base_r  <= base_r + MA_W'(QWORDS);
      end else begin
        word_r  <= word_r + QA_W'(1);
      end
    end
  end

  // Best and second best; a distance equal to the best does not replace it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r   <= DIST_NONE;
      second_r <= DIST_NONE;
      bidx_r   <= '0;
    end else if (start) begin
      best_r   <= DIST_NONE;
      second_r <= DIST_NONE;
      bidx_r   <= '0;
    end else if (dist_valid) begin
      if (entry_dist < best_r) begin
        second_r <= best_r;
        best_r   <= entry_dist;
        bidx_r   <= dist_entry;
      end else if (entry_dist < second_r) begin
        second_r <= entry_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RATIO) begin
      prod5_r <= (P_W'(best_r) << 2) + P_W'(best_r);
      prod3_r <= (P_W'(second_r) << 1) + P_W'(second_r);
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.match_found     <= match;
      out_data_r.neighbor_index  <= match ? 8'(bidx_r) : 8'd0;
      out_data_r.best_distance   <= best_r;
      out_data_r.second_distance <= second_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- units
  dnnr_store #(
    .MAX_MODELS (MAX_MODELS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_store (
    .clk         (clk),
    .model_we    (model_we),
    .model_waddr (model_waddr),
    .sign_waddr  (ent_ext[EW-1:0]),
    .sign_wdata  (in_data.laplacian_sign),
    .query_we    (query_we),
    .query_waddr (QA_W'(in_data.element_index >> 2)),
    .wlane       (in_data.element_index[1:0]),
    .wdata       (in_data.value),
    .model_raddr (base_r + MA_W'(word_r)),
    .query_raddr (word_r),
    .sign_raddr  (entry_r),
    .model_rdata (model_rdata),
    .query_rdata (query_rdata),
    .sign_rdata  (sign_rdata)
  );

  dnnr_dist #(
    .MAX_MODELS (MAX_MODELS)
  ) u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag_in      (p1_tag_r),
    .entry_in    (p1_entry_r),
    .sign_in     (sign_rdata),
    .query_sign  (qsign_r),
    .model_rdata (model_rdata),
    .query_rdata (query_rdata),
    .busy        (dist_busy),
    .dist_valid  (dist_valid),
    .entry_dist  (entry_dist),
    .dist_entry  (dist_entry)
  );

endmodule

`default_nettype wire

/* sv/dnnr_store.sv */
// Model, query and sign memories of the descriptor nearest-neighbor ratio block.
`default_nettype none

module dnnr_store
  import dnnr_pkg::*;
#(
  parameter int MAX_MODELS = MAX_MODELS_DEF,
  parameter int MAX_LENGTH = MAX_LENGTH_DEF,
  localparam int QWORDS = (MAX_LENGTH + LANES - 1) / LANES,
  localparam int MA_W   = $clog2(MAX_MODELS * QWORDS),
  localparam int QA_W   = (QWORDS > 1) ? $clog2(QWORDS) : 1,
  localparam int EW     = $clog2(MAX_MODELS)
) (
  input  wire                               clk,
  input  wire                               model_we,
  input  wire  [MA_W-1:0]                   model_waddr,
  input  wire  [EW-1:0]                     sign_waddr,
  input  wire                               sign_wdata,
  input  wire                               query_we,
  input  wire  [QA_W-1:0]                   query_waddr,
  input  wire  [1:0]                        wlane,
  input  wire  [VAL_W-1:0]                  wdata,
  input  wire  [MA_W-1:0]                   model_raddr,
  input  wire  [QA_W-1:0]                   query_raddr,
  input  wire  [EW-1:0]                     sign_raddr,
  output logic [LANES-1:0][VAL_W-1:0]       model_rdata,
  output logic [LANES-1:0][VAL_W-1:0]       query_rdata,
  output logic                              sign_rdata
);

  logic [LANES-1:0][VAL_W-1:0] model_mem [MAX_MODELS * QWORDS];
  logic [LANES-1:0][VAL_W-1:0] query_mem [QWORDS];
  logic                        sign_mem  [MAX_MODELS];

  // Each element write touches one lane of its word; every model write also
  // sets the entry's sign.
  always_ff @(posedge clk) begin
    if (model_we) begin
      model_mem[model_waddr][wlane] <= wdata;
    end
    model_rdata <= model_mem[model_raddr];
  end

  always_ff @(posedge clk) begin
    if (model_we) begin
      sign_mem[sign_waddr] <= sign_wdata;
    end
    sign_rdata <= sign_mem[sign_raddr];
  end

  always_ff @(posedge clk) begin
    if (query_we) begin
      query_mem[query_waddr][wlane] <= wdata;
    end
    query_rdata <= query_mem[query_raddr];
  end

endmodule

`default_nettype wire

/* sv/dnnr_dist.sv */
// Squared-difference pipeline that accumulates the distance of one model entry.
`default_nettype none

module dnnr_dist
  import dnnr_pkg::*;
#(
  parameter int MAX_MODELS = MAX_MODELS_DEF,
  localparam int EW = $clog2(MAX_MODELS)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  word_tag_t              tag_in,
  input  wire  [EW-1:0]                entry_in,
  input  wire                          sign_in,
  input  wire                          query_sign,
  input  wire  [LANES-1:0][VAL_W-1:0]  model_rdata,
  input  wire  [LANES-1:0][VAL_W-1:0]  query_rdata,
  output logic                         busy,
  output logic                         dist_valid,
  output logic [DIST_W-1:0]            entry_dist,
  output logic [EW-1:0]                dist_entry
);

  // Stage 2: squares of the lane differences.
  logic [LANES-1:0][SQ_W-1:0] sq_r;
  logic [LANES-1:0][SQ_W-1:0] sq_nxt;
  word_tag_t                  p2_tag_r;
  logic                       p2_hit_r;
  logic [EW-1:0]              p2_entry_r;

  // Stage 3: sum of the four squares.
  logic [SUM_W-1:0]           sum_r;
  logic [SUM_W-1:0]           sum_nxt;
  word_tag_t                  p3_tag_r;
  logic                       p3_hit_r;
  logic [EW-1:0]              p3_entry_r;

  // Stage 4: running distance of the current entry.
  logic [DIST_W-1:0]          acc_r;
  logic [DIST_W-1:0]          acc_nxt;
  logic                       done_r;
  logic [EW-1:0]              done_entry_r;

  always_comb begin
    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] prod;
    for (int l = 0; l < LANES; l++) begin
      diff = $signed({query_rdata[l][VAL_W-1], query_rdata[l]}) -
             $signed({model_rdata[l][VAL_W-1], model_rdata[l]});
      prod = diff * diff;
      sq_nxt[l] = tag_in.mask[l] ? prod[SQ_W-1:0] : '0;
    end
  end

  assign sum_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) +
                   SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);

  assign acc_nxt = p3_tag_r.first ? DIST_W'(sum_r) : acc_r + DIST_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_tag_r.valid <= 1'b0;
      p3_tag_r.valid <= 1'b0;
      done_r         <= 1'b0;
    end else begin
      p2_tag_r.valid <= tag_in.valid;
      p3_tag_r.valid <= p2_tag_r.valid;
      done_r         <= p3_tag_r.valid && p3_tag_r.last && p3_hit_r;
    end

    sq_r                <= sq_nxt;
    p2_tag_r.first      <= tag_in.first;
    p2_tag_r.last       <= tag_in.last;
    p2_tag_r.mask       <= tag_in.mask;
    p2_hit_r            <= (sign_in == query_sign);
    p2_entry_r          <= entry_in;

    sum_r               <= sum_nxt;
    p3_tag_r.first      <= p2_tag_r.first;
    p3_tag_r.last       <= p2_tag_r.last;
    p3_tag_r.mask       <= p2_tag_r.mask;
    p3_hit_r            <= p2_hit_r;
    p3_entry_r          <= p2_entry_r;

    if (p3_tag_r.valid) begin
      acc_r <= acc_nxt;
    end
    done_entry_r        <= p3_entry_r;
  end

  assign busy       = tag_in.valid || p2_tag_r.valid || p3_tag_r.valid || done_r;
  assign dist_valid = done_r;
  assign entry_dist = acc_r;
  assign dist_entry = done_entry_r;

endmodule

`default_nettype wire

/* sim/descriptor_nearest_neighbor_ratio_test.sv */
// Self-checking testbench for the descriptor nearest-neighbor ratio block.
`timescale 1ns / 1ps

module descriptor_nearest_neighbor_ratio_test
  import dnnr_pkg::*;
();

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int REPORT_LIMIT  = 10;
  localparam int N_MODELS      = MAX_MODELS_DEF;
  localparam int N_ELEMS       = MAX_LENGTH_DEF;
  localparam int ITEM_TARGET   = 1800;
  localparam int SEARCH_TARGET = 24;

  localparam out_item_t NO_CANDIDATE = '{1'b0, 8'd0, DIST_NONE, DIST_NONE};
  localparam out_item_t SOLE_EXACT   = '{1'b1, 8'd0, 39'd0, DIST_NONE};
  localparam out_item_t ZERO_TIE     = '{1'b0, 8'd0, 39'd0, 39'd0};

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    int unsigned wdata;
    in_item_t    item;
    bit          typed;
    out_item_t   result;
  } stim_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Shadow copy of the block's stores and registers.
  logic signed [15:0]       mdl_val     [N_MODELS][N_ELEMS];
  bit                       mdl_sign    [N_MODELS];
  bit                       mdl_written [N_MODELS][N_ELEMS];
  logic signed [15:0]       qry_val     [N_ELEMS];
  bit                       qry_written [N_ELEMS];
  logic [MODEL_COUNT_W-1:0] set_count = MODEL_COUNT_RST;
  logic [DESC_LEN_W-1:0]    set_len   = DESC_LEN_RST;

  out_item_t   search_outcomes[$];
  stim_row_t   dir_rows[$];
  int unsigned items_accepted  = 0;
  int unsigned searches_issued = 0;
  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;
  bit          sender_burst    = 1'b0;

  descriptor_nearest_neighbor_ratio uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t make_item(int unsigned f, int unsigned entry,
                                         int unsigned elem, int unsigned value,
                                         int unsigned sign, int unsigned last);
    in_item_t it;
    it.func           = f[0];
    it.entry_index    = 8'(entry);
    it.element_index  = 7'(elem);
    it.value          = 16'(value);
    it.laplacian_sign = sign[0];
    it.last           = last[0];
    return it;
  endfunction

  function automatic longint unsigned sq_distance(int e, int len);
    longint unsigned total;
    longint          d;
    total = 0;
    for (int i = 0; i < len; i++) begin
      d = longint'(qry_val[i]) - longint'(mdl_val[e][i]);
      total += longint'(d * d);
    end
    return total;
  endfunction

  function automatic out_item_t ratio_search(bit sgn);
    longint unsigned best, second, d;
    int              best_idx, lim, len;
    bit              hit;
    out_item_t       res;
    best     = DIST_NONE;
    second   = DIST_NONE;
    best_idx = 0;
    lim = (int'(set_count) > N_MODELS) ? N_MODELS : int'(set_count);
    len = (int'(set_len) > N_ELEMS) ? N_ELEMS : int'(set_len);
    for (int e = 0; e < lim; e++) begin
      if (mdl_sign[e] != sgn) continue;
      d = sq_distance(e, len);
      // An equal distance leaves the current best in place.
      if (d < best) begin
        second   = best;
        best     = d;
        best_idx = e;
      end else if (d < second) begin
        second = d;
      end
    end
    hit = (best * 5) < (second * 3);
    res.match_found     = hit;
    res.neighbor_index  = hit ? 8'(best_idx) : 8'd0;
    res.best_distance   = best[38:0];
    res.second_distance = second[38:0];
    return res;
  endfunction

  // Indexes cannot leave the stores at these field widths, so no write is dropped.
  function automatic bit absorb_item(in_item_t it, output out_item_t res);
    res = '0;
    if (it.func == FUNC_MODEL) begin
      mdl_val[it.entry_index][it.element_index]     = it.value;
      mdl_written[it.entry_index][it.element_index] = 1'b1;
      mdl_sign[it.entry_index]                      = it.laplacian_sign;
      return 1'b0;
    end
    qry_val[it.element_index]     = it.value;
    qry_written[it.element_index] = 1'b1;
    if (!it.last) return 1'b0;
    res = ratio_search(it.laplacian_sign);
    return 1'b1;
  endfunction

  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t typed_res = '0);
    int        gap;
    out_item_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_accepted++;
    if (absorb_item(it, res)) begin
      search_outcomes.insert(search_outcomes.size(), typed ? typed_res : res);
      searches_issued++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (search_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(cfg_reg_t r, int unsigned v);
    logic [CFG_DW-1:0] want;
    want = (r == REG_MODEL_COUNT) ? CFG_DW'(v[MODEL_COUNT_W-1:0]) : CFG_DW'(v[DESC_LEN_W-1:0]);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    // The write lands at this edge; the same register is then read back.
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("register %s read back: expected %0h, got %0h", r.name(), want, prdata);
    end
    if (r == REG_MODEL_COUNT) set_count = v[MODEL_COUNT_W-1:0];
    else set_len = v[DESC_LEN_W-1:0];
  endtask

  task automatic add_cfg(cfg_reg_t r, int unsigned v);
    stim_row_t row;
    row = '{ROW_CFG, r, v, '0, 1'b0, '0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_item(in_item_t it, bit typed = 1'b0, out_item_t res = '0);
    stim_row_t row;
    row = '{ROW_ITEM, REG_MODEL_COUNT, 0, it, typed, res};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // One setting: fill every searched entry up to whole memory words, then queries.
  task automatic run_phase(int unsigned cnt, int unsigned len, int nq);
    int          lim, eff, need, tgt, kind, amp, rot, k;
    bit          sgn, fill_sign, nf;
    logic [15:0] val;
    wait_drained();
    set_register(REG_MODEL_COUNT, cnt);
    set_register(REG_DESC_LEN, len);
    sender_burst = ($urandom_range(0, 3) == 0);
    lim  = (int'(set_count) > N_MODELS) ? N_MODELS : int'(set_count);
    eff  = (int'(set_len) > N_ELEMS) ? N_ELEMS : int'(set_len);
    need = (eff == 0) ? LANES : ((eff + LANES - 1) / LANES) * LANES;
    for (int e = 0; e < lim; e++) begin
      if (lim <= 16 && e > 0 && $urandom_range(0, 5) == 0) begin
        // Duplicate of the previous entry, so that equal distances occur.
        for (int i = 0; i < need; i++)
          send_item(make_item(FUNC_MODEL, e, i, mdl_val[e-1][i], mdl_sign[e-1], $urandom));
      end else begin
        fill_sign = $urandom;
        for (int i = 0; i < need; i++)
          if (!mdl_written[e][i])
            send_item(make_item(FUNC_MODEL, e, i, $urandom, fill_sign, $urandom));
      end
    end
    repeat (nq) begin
      tgt  = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
      kind = $urandom_range(0, 9);
      amp  = (kind < 3) ? 2 : (kind < 6) ? 200 : 0;
      sgn  = ($urandom_range(0, 4) == 0) ? 1'($urandom) : mdl_sign[tgt];
      rot  = $urandom_range(0, need - 1);
      for (int i = 0; i < need; i++) begin
        k = (i + rot) % need;
        if ($urandom_range(0, 9) == 0) begin
          nf = $urandom;
          send_item(make_item(nf, $urandom, $urandom, $urandom, $urandom,
                              (nf == FUNC_MODEL) ? 1'($urandom) : 1'b0));
        end
        // Broken sequence: some query elements keep their old values.
        if (kind == 9 && i != need - 1 && qry_written[k] && $urandom_range(0, 2) != 0)
          continue;
        if (kind == 6 || kind == 7 || !mdl_written[tgt][k]) val = $urandom;
        else val = mdl_val[tgt][k] + 16'($urandom_range(0, 2 * amp) - amp);
        send_item(make_item(FUNC_QUERY, $urandom, k, val,
                            (i == need - 1) ? sgn : 1'($urandom), i == need - 1));
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (search_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with none expected: %p", out_data);
      end else begin
        want = search_outcomes.pop_front();
        if (out_data.match_found !== want.match_found ||
            out_data.neighbor_index !== want.neighbor_index ||
            out_data.best_distance !== want.best_distance ||
            out_data.second_distance !== want.second_distance) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     want.match_found, want.neighbor_index, want.best_distance,
                     want.second_distance, out_data.match_found, out_data.neighbor_index,
                     out_data.best_distance, out_data.second_distance);
        end
      end
    end
  end

  // Receiver: a random stall before each result, quiet stretches, and a few long holds.
  initial begin
    int          n;
    int unsigned got;
    got = 0;
    forever begin
      if (got == 20 || got == 40 || got == 60) n = LONG_HOLD;
      else if ((got / 16) % 3 == 2) n = 0;
      else n = $urandom_range(0, 15);
      out_stall <= (n > 0);
      if (n > 0) begin
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned len_pick;

    add_cfg(REG_DESC_LEN, 4);
    add_item(make_item(FUNC_QUERY, 0, 0, 16'h7FFF, 0, 0));
    add_item(make_item(FUNC_QUERY, 0, 1, 16'h8000, 1, 0));
    add_item(make_item(FUNC_QUERY, 255, 2, 16'h0000, 0, 0));
    // Nothing is searched while model_count is still at its reset value.
    add_item(make_item(FUNC_QUERY, 0, 3, 16'hFFFF, 1, 1), 1'b1, NO_CANDIDATE);
    add_item(make_item(FUNC_MODEL, 0, 0, 16'h7FFF, 1, 0));
    add_item(make_item(FUNC_MODEL, 0, 1, 16'h8000, 1, 1));
    add_item(make_item(FUNC_MODEL, 0, 2, 16'h0000, 1, 0));
    add_item(make_item(FUNC_MODEL, 0, 3, 16'hFFFF, 1, 0));
    add_cfg(REG_MODEL_COUNT, 1);
    add_item(make_item(FUNC_QUERY, 0, 3, 16'hFFFF, 1, 1), 1'b1, SOLE_EXACT);
    add_item(make_item(FUNC_QUERY, 0, 3, 16'hFFFF, 0, 1), 1'b1, NO_CANDIDATE);
    add_item(make_item(FUNC_MODEL, 1, 0, 16'h8000, 1, 0));
    add_item(make_item(FUNC_MODEL, 1, 1, 16'h7FFF, 1, 0));
    add_item(make_item(FUNC_MODEL, 1, 2, 16'h8000, 1, 0));
    add_item(make_item(FUNC_MODEL, 1, 3, 16'h7FFF, 1, 0));
    add_cfg(REG_MODEL_COUNT, 2);
    add_item(make_item(FUNC_QUERY, 0, 3, 16'hFFFF, 1, 1));
    add_item(make_item(FUNC_QUERY, 0, 0, 16'h8000, 1, 1));
    add_item(make_item(FUNC_MODEL, 255, 127, 16'h7FFF, 1, 0));
    add_item(make_item(FUNC_QUERY, 128, 127, 16'h8000, 0, 0));
    add_cfg(REG_DESC_LEN, 0);
    // With no elements compared both entries sit at distance zero and tie.
    add_item(make_item(FUNC_QUERY, 0, 0, 16'h7FFF, 1, 1), 1'b1, ZERO_TIE);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        set_register(dir_rows[i].reg_sel, dir_rows[i].wdata);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
      end
    end

    // Register extremes: empty model set, a count past the store, zero and
    // oversized lengths, and a length that is not a whole number of words.
    run_phase(0, 64, 1);
    run_phase(511, 4, 3);
    run_phase(256, 0, 2);
    run_phase(2, 255, 1);
    run_phase(7, 13, 3);

    while (items_accepted < ITEM_TARGET || searches_issued < SEARCH_TARGET) begin
      len_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 128) : $urandom_range(0, 24);
      run_phase($urandom_range(0, 12), len_pick, $urandom_range(3, 8));
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/dnnr_pkg.sv
sv/dnnr_store.sv
sv/dnnr_dist.sv
sv/descriptor_nearest_neighbor_ratio.sv
sim/descriptor_nearest_neighbor_ratio_test.sv
